[sv/psv_pkg.sv]
// Shared definitions for the prime sieve: default sizes and the command and
// status groups that link the controller to the datapath. No dependencies.
package psv_pkg;

  localparam int MaxPrimesDef  = 64;
  localparam int ValueWidthDef = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // capture the accepted request
    logic rd;         // read the stored prime at the current index
    logic div_init;   // load the divisor from the memory, clear the remainder
    logic div_step;   // one restoring division step
    logic next_idx;   // advance to the next stored prime
    logic emit;       // store the survivor and load the output register
    logic finish;     // item done; clears the store on the last of a run
  } psv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cand_small;  // candidate is zero or one
    logic idx_at_end;  // every stored prime has been tried
    logic div_last;    // this division step is the final one
    logic rem_zero;    // remainder of the finished division is zero
    logic out_free;    // output register can take a result this cycle
  } psv_status_t;

endpackage

[sv/pipelined_prime_sieve.sv]
// Top level of the prime sieve: stream ports, controller and datapath.
// Depends on psv_pkg, psv_ctrl and psv_dp.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: number; tlast: end_of_run
//   m_axis   out        tdata: prime_value; tuser: store_full
//
// A request is tested against each of the n stored primes in turn, one
// division each, and stops early at the first prime that divides it; the
// serial remainder unit that does each division takes one bit per cycle.
// Reset clears the prime count and the output valid; the store needs no clear.
// The output register holds a result while m_axis stalls, and the next
// request is accepted meanwhile; a survivor waits only if the register is full.
module pipelined_prime_sieve #(
  parameter int MAX_PRIMES  = psv_pkg::MaxPrimesDef,
  parameter int VALUE_WIDTH = psv_pkg::ValueWidthDef,
  parameter int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [VALUE_WIDTH-1:0] number
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [VALUE_WIDTH-1:0] prime_value
  output logic              m_axis_tuser    // [0] store_full
);
  import psv_pkg::*;

  psv_cmd_t               cmd;
  psv_status_t            status;
  logic [VALUE_WIDTH-1:0] out_value;

  psv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psv_dp #(
    .MAX_PRIMES  (MAX_PRIMES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_number_i (s_axis_tdata[VALUE_WIDTH-1:0]),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_full_o  (m_axis_tuser)
  );

  assign m_axis_tdata = DATA_W'(out_value);

endmodule

[sv/psv_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module psv_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/psv_ctrl.sv]
// Sequencing state machine of the prime sieve.
// Depends on psv_pkg for the command and status groups.
module psv_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  psv_pkg::psv_status_t  status_i,
  output psv_pkg::psv_cmd_t     cmd_o
);
  import psv_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_READ  = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_TEST  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } psv_state_e;

  psv_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        if (status_i.cand_small) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end else if (status_i.idx_at_end) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.rem_zero) begin
          // A stored prime divides the candidate, so it is dropped.
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.next_idx = 1'b1;
          state_d = S_START;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A division always runs to its last step before the result is tested.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST) |-> $past(status_i.div_last))
    else $error("remainder tested before the division finished");

  // An emit never happens without room in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result emitted into a busy output register");

  // A new request is only taken once the previous item has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> !in_ready_o)
    else $error("request taken while an item is in progress");

endmodule

[sv/psv_dp.sv]
// Datapath of the prime sieve: item registers, prime store, serial remainder
// unit and the output register. Depends on psv_pkg and psv_ram.
module psv_dp #(
  parameter int MAX_PRIMES  = psv_pkg::MaxPrimesDef,
  parameter int VALUE_WIDTH = psv_pkg::ValueWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  psv_pkg::psv_cmd_t       cmd_i,
  output psv_pkg::psv_status_t    status_o,
  input  logic [VALUE_WIDTH-1:0]  in_number_i,
  input  logic                    in_last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [VALUE_WIDTH-1:0]  out_value_o,
  output logic                    out_full_o
);
  import psv_pkg::*;

  localparam int CntW  = $clog2(MAX_PRIMES + 1);
  localparam int AddrW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int BitW  = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] cand_q;
  logic                   last_q;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [BitW-1:0]        bit_q;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  logic                   out_full_q;

  logic                   store_has_room;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic [VALUE_WIDTH:0]   trial;
  logic                   trial_ge;

  assign store_has_room = (count_q < CntW'(MAX_PRIMES));

  psv_ram #(
    .WIDTH  (VALUE_WIDTH),
    .DEPTH  (MAX_PRIMES),
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.emit && store_has_room),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (cand_q),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Restoring division, one candidate bit per cycle from the top.
  assign trial    = {rem_q, cand_q[bit_q]};
  assign trial_ge = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cand_q <= in_number_i;
      last_q <= in_last_i;
    end
    if (cmd_i.div_init) begin
      div_q <= ram_rdata;
      rem_q <= '0;
      bit_q <= BitW'(VALUE_WIDTH - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? VALUE_WIDTH'(trial - {1'b0, div_q}) : trial[VALUE_WIDTH-1:0];
      bit_q <= bit_q - 1'b1;
    end
    if (cmd_i.emit) begin
      out_value_q <= cand_q;
      out_full_q  <= !store_has_room;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.emit && store_has_room) begin
      count_d = count_q + 1'b1;
    end
    // The end of a run empties the store after its own candidate.
    if (cmd_i.finish && last_q) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load_item) begin
        idx_q <= '0;
      end else if (cmd_i.next_idx) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.cand_small = (cand_q < VALUE_WIDTH'(2));
  assign status_o.idx_at_end = (idx_q == count_q);
  assign status_o.div_last   = (bit_q == '0);
  assign status_o.rem_zero   = (rem_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_full_o  = out_full_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PRIMES))
    else $error("prime count beyond the store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (idx_q < count_q))
    else $error("read of a store entry that holds no prime");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (div_q >= VALUE_WIDTH'(2)))
    else $error("division by a value below two");

endmodule

[bench/prime_sieve_checker.sv]
`timescale 1ns / 100ps
// Result checker for pipelined_prime_sieve. It keeps its own prime store, predicts the
// survivor of every accepted candidate and compares output requests in order.
// Depends on psv_pkg for the default sizes.
module prime_sieve_checker #(
  parameter int MAX_PRIMES  = psv_pkg::MaxPrimesDef,
  parameter int VALUE_WIDTH = psv_pkg::ValueWidthDef,
  parameter int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cand_valid_i,
  input  logic              cand_ready_i,
  input  logic [DATA_W-1:0] cand_data_i,
  input  logic              cand_last_i,
  input  logic              prime_valid_i,
  input  logic              prime_ready_i,
  input  logic [DATA_W-1:0] prime_data_i,
  input  logic              prime_full_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   full;
  } prime_result_t;

  logic [VALUE_WIDTH-1:0] known_primes [MAX_PRIMES];
  int                     num_known;
  prime_result_t          expected_primes [$];
  prime_result_t          want;
  prime_result_t          survivor;

  // Tests a candidate against the stored primes; a survivor is stored while
  // there is room and reported either way.
  function automatic bit sieve_candidate(input logic [VALUE_WIDTH-1:0] cand,
                                         output prime_result_t res);
    bit divided;
    divided = 1'b0;
    res     = '0;
    if (cand < 2) return 1'b0;
    for (int i = 0; i < num_known; i++) begin
      if (cand % known_primes[i] == 0) divided = 1'b1;
    end
    if (divided) return 1'b0;
    res.value = cand;
    res.full  = (num_known == MAX_PRIMES);
    if (!res.full) begin
      known_primes[num_known] = cand;
      num_known++;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_primes.delete();
      num_known = 0;
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // Results always trail their candidate, so the output side is checked before
      // this cycle's input is predicted.
      if (prime_valid_i && prime_ready_i) begin
        if (expected_primes.size() == 0) begin
          $error("prime_value: expected no result, actual %0d", prime_data_i);
          errors_o++;
        end else begin
          want = expected_primes.pop_front();
          if (prime_data_i !== DATA_W'(want.value)) begin
            $error("prime_value: expected %0d, actual %0d", want.value, prime_data_i);
            errors_o++;
          end
          if (prime_full_i !== want.full) begin
            $error("store_full: expected %0d, actual %0d", want.full, prime_full_i);
            errors_o++;
          end
        end
      end
      if (cand_valid_i && cand_ready_i) begin
        if (sieve_candidate(cand_data_i[VALUE_WIDTH-1:0], survivor)) begin
          expected_primes.push_back(survivor);
        end
        if (cand_last_i) num_known = 0;
      end
      pending_o = expected_primes.size();
    end
  end

endmodule

[bench/pipelined_prime_sieve_tb.sv]
`timescale 1ns / 100ps
// Testbench for pipelined_prime_sieve: sends directed and random candidate runs with
// random gaps and output stalls, and reports the verdict of prime_sieve_checker.
// Depends on psv_pkg, pipelined_prime_sieve and prime_sieve_checker.
module pipelined_prime_sieve_tb;

  localparam int MaxPrimes   = psv_pkg::MaxPrimesDef;
  localparam int ValueWidth  = psv_pkg::ValueWidthDef;
  localparam int DataW       = ((ValueWidth + 7) / 8) * 8;
  localparam int SieveCycles = 3 + MaxPrimes * (ValueWidth + 4);
  localparam int NumItems    = 1600;

  typedef struct packed {
    logic                  last;
    logic [ValueWidth-1:0] num;
  } candidate_t;

  // Opens with zero and one, an unordered composite, values at the top of the
  // range and run ends that fall on dropped candidates.
  localparam candidate_t DirectedSet [20] = '{
    '{1'b0, 0},     '{1'b0, 1},     '{1'b0, 2},     '{1'b0, 3},     '{1'b0, 4},
    '{1'b0, 25},    '{1'b0, 5},     '{1'b0, 65535}, '{1'b0, 65521}, '{1'b0, 35},
    '{1'b1, 1},     '{1'b0, 65535}, '{1'b0, 32768}, '{1'b0, 65534}, '{1'b1, 0},
    '{1'b0, 2},     '{1'b0, 4},     '{1'b0, 9},     '{1'b0, 3},     '{1'b1, 6}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic [DataW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tready = 1'b0;
  wire              s_axis_tready;
  wire              m_axis_tvalid;
  wire  [DataW-1:0] m_axis_tdata;
  wire              m_axis_tuser;

  int mismatches;
  int pending;
  int sent       = 0;
  int burst_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pipelined_prime_sieve u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  prime_sieve_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cand_valid_i  (s_axis_tvalid),
    .cand_ready_i  (s_axis_tready),
    .cand_data_i   (s_axis_tdata),
    .cand_last_i   (s_axis_tlast),
    .prime_valid_i (m_axis_tvalid),
    .prime_ready_i (m_axis_tready),
    .prime_data_i  (m_axis_tdata),
    .prime_full_i  (m_axis_tuser),
    .errors_o      (mismatches),
    .pending_o     (pending)
  );

  // Sends one candidate; the sender idles for a random gap whenever a burst
  // runs out, and some bursts are long enough to leave no gaps at all.
  task automatic offer_candidate(input logic [ValueWidth-1:0] num, input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DataW'(num);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int run_len;
    int extra;
    int noise_len;
    bit close_run;
    bit paused;
    logic [ValueWidth-1:0] noise;
    paused = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirectedSet[i]) offer_candidate(DirectedSet[i].num, DirectedSet[i].last);
    drain_results();

    while (sent < NumItems) begin
      if ($urandom_range(0, 99) < 80) begin
        // A run counting up from 2; the rare long one overflows the store.
        run_len   = ($urandom_range(0, 11) == 0) ? $urandom_range(320, 400)
                                                 : $urandom_range(2, 60);
        extra     = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        close_run = ($urandom_range(0, 19) != 0);
        for (int k = 0; k < run_len; k++) begin
          offer_candidate(ValueWidth'(k + 2), close_run && extra == 0 && k == run_len - 1);
        end
        for (int k = 0; k < extra; k++) begin
          offer_candidate(ValueWidth'($urandom), close_run && k == extra - 1);
        end
      end else begin
        noise_len = $urandom_range(1, 8);
        for (int k = 0; k < noise_len; k++) begin
          noise = ($urandom_range(0, 7) == 0) ? ValueWidth'($urandom_range(0, 1))
                                              : ValueWidth'($urandom);
          offer_candidate(noise, k == noise_len - 1 || $urandom_range(0, 9) == 0);
        end
      end
      if (!paused && sent >= NumItems / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SieveCycles + 50) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("pipelined_prime_sieve_tb: PASS");
    end else begin
      $display("pipelined_prime_sieve_tb: FAIL");
    end
    $finish;
  end

  // The receiver changes its stall pattern from phase to phase and now and
  // then holds off long enough for the block to back up its input.
  initial begin : receiver
    int got;
    int hold_at;
    int phase_left;
    int phase_mode;
    got        = 0;
    hold_at    = 30;
    phase_left = 0;
    phase_mode = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) got++;
      if (got >= hold_at) begin
        hold_at += 700;
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else begin
        if (phase_left == 0) begin
          phase_mode = $urandom_range(0, 2);
          phase_left = $urandom_range(16, 256);
        end
        phase_left--;
        case (phase_mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    #(30_000_000);
    $display("pipelined_prime_sieve_tb: FAIL");
    $finish;
  end

endmodule
